// ----- sv/inband_command_serial_mux_defines.svh -----
// assertion macros for the inband command serial mux
// used by the top level; expects signals named clock and reset in scope
`ifndef INBAND_COMMAND_SERIAL_MUX_DEFINES_SVH
`define INBAND_COMMAND_SERIAL_MUX_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ICSM_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("icsm: implication check failed");
// expression must never be true outside reset
`define ICSM_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("icsm: forbidden condition seen");
`else
`define ICSM_ASSERT_IMPLY(label, ante, cons)
`define ICSM_ASSERT_NEVER(label, expr)
`endif

`endif

// ----- sv/icsm_pkg.sv -----
// shared types and codes for the inband command serial mux
// no dependencies
`default_nettype none

package icsm_pkg;

   // parse modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ARG    = 2'd1;
   localparam logic [1:0] MODE_RAW    = 2'd2;

   // device ids
   localparam logic [1:0] DEV_BUOY   = 2'd0;
   localparam logic [1:0] DEV_SENSOR = 2'd1;
   localparam logic [1:0] DEV_MODEM  = 2'd2;

   // command codes
   localparam logic [2:0] CMD_ANTENNA  = 3'd1;
   localparam logic [2:0] CMD_RAW_BYTE = 3'd2;
   localparam logic [2:0] CMD_CONNECT  = 3'd3;
   localparam logic [2:0] CMD_POWEROFF = 3'd4;
   localparam logic [2:0] CMD_RAW_LEN  = 3'd5;

   // back-end operations
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_FWD      = 3'd1;
   localparam logic [2:0] OP_ANT_GPS  = 3'd2;
   localparam logic [2:0] OP_ANT_SAT  = 3'd3;
   localparam logic [2:0] OP_CONNECT  = 3'd4;
   localparam logic [2:0] OP_POWEROFF = 3'd5;

   // argument letters
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_I = 8'h49;
   localparam logic [7:0] CHAR_S = 8'h53;
   localparam logic [7:0] CHAR_B = 8'h42;

   // bytes below this open a command
   localparam logic [7:0] CMD_LIMIT = 8'd8;

   localparam int RAW_COUNT_BITS_DEFAULT = 8;

   // power reset: buoy on, sensor on, modem off
   localparam logic [2:0] POWER_RESET = 3'b011;

   // operation passed from the front to the back
   typedef struct packed {
      logic [2:0] op;
      logic [1:0] dev;
      logic [7:0] data;
      logic [1:0] mode;
   } icsm_entry_type;

endpackage

`default_nettype wire

// ----- sv/inband_command_serial_mux.sv -----
// In-band command serial mux: takes one byte per transaction from the downstream
// link and returns one result per byte, carrying the forwarded byte (if any) and
// the antenna, power, link and parse state after that byte. One byte is accepted
// every clock cycle while results are taken; a result appears once its byte has
// passed through the parser-to-executor queue and the output register. While
// the result side stalls the parser keeps taking bytes until the two-entry queue
// is full: one more byte when streaming back to back, two after an idle gap.
// depends on icsm_pkg, icsm_front, icsm_queue, icsm_back and the defines header
`default_nettype none

`include "inband_command_serial_mux_defines.svh"

module inband_command_serial_mux #(
   parameter int RAW_COUNT_BITS = icsm_pkg::RAW_COUNT_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_fwd_valid,
   output logic [1:0]      rsp_fwd_dest,
   output logic [7:0]      rsp_fwd_data,
   output logic            rsp_antenna_sel,
   output logic            rsp_pwr_buoy,
   output logic            rsp_pwr_sensor,
   output logic            rsp_pwr_modem,
   output logic [1:0]      rsp_linked_dev,
   output logic            rsp_link_open,
   output logic [1:0]      rsp_parse_mode
);

   icsm_pkg::icsm_entry_type push_entry;
   icsm_pkg::icsm_entry_type pop_entry;
   logic                     pop_valid;
   logic                     pop_stall;

   // parser
   icsm_front #(
      .RAW_COUNT_BITS(RAW_COUNT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .push_stall  (req_stall),
      .push_entry  (push_entry)
   );

   // decoupling queue
   icsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_entry (push_entry),
      .push_stall (req_stall),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_stall  (pop_stall)
   );

   // executor and output register
   icsm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_entry       (pop_entry),
      .pop_stall       (pop_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fwd_valid   (rsp_fwd_valid),
      .rsp_fwd_dest    (rsp_fwd_dest),
      .rsp_fwd_data    (rsp_fwd_data),
      .rsp_antenna_sel (rsp_antenna_sel),
      .rsp_pwr_buoy    (rsp_pwr_buoy),
      .rsp_pwr_sensor  (rsp_pwr_sensor),
      .rsp_pwr_modem   (rsp_pwr_modem),
      .rsp_linked_dev  (rsp_linked_dev),
      .rsp_link_open   (rsp_link_open),
      .rsp_parse_mode  (rsp_parse_mode)
   );

   // checks
   `ICSM_ASSERT_IMPLY(a_fwd_needs_open, rsp_valid && rsp_fwd_valid, rsp_link_open)
   `ICSM_ASSERT_IMPLY(a_idle_fields_zero, rsp_valid && !rsp_fwd_valid,
      (rsp_fwd_data == 8'd0) && (rsp_fwd_dest == icsm_pkg::DEV_BUOY))
   `ICSM_ASSERT_IMPLY(a_closed_on_buoy, rsp_valid && !rsp_link_open,
      rsp_linked_dev == icsm_pkg::DEV_BUOY)
   `ICSM_ASSERT_IMPLY(a_open_dev_powered, rsp_valid && rsp_link_open,
      (rsp_linked_dev == icsm_pkg::DEV_BUOY && rsp_pwr_buoy) ||
      (rsp_linked_dev == icsm_pkg::DEV_SENSOR && rsp_pwr_sensor) ||
      (rsp_linked_dev == icsm_pkg::DEV_MODEM && rsp_pwr_modem))
   `ICSM_ASSERT_NEVER(a_mode_code, rsp_valid && (rsp_parse_mode == 2'd3))

endmodule

`default_nettype wire

// ----- sv/icsm_front.sv -----
// front end: byte parser that tracks command and raw modes
// and turns each byte into one back-end operation; uses icsm_pkg
`default_nettype none

module icsm_front #(
   parameter int RAW_COUNT_BITS = icsm_pkg::RAW_COUNT_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic [7:0]               req_rx_byte,
   input  wire logic                     push_stall,
   output icsm_pkg::icsm_entry_type      push_entry
);

   logic [1:0]                mode_ff, mode_in;
   logic [2:0]                pending_ff, pending_in;
   logic [RAW_COUNT_BITS-1:0] raw_count_ff, raw_count_in;
   logic [1:0]                letter_dev;
   logic                      letter_ok;
   logic                      accept;

   assign accept = req_valid && !push_stall;

   // device letter decode
   always_comb begin
      letter_ok  = 1'b1;
      letter_dev = icsm_pkg::DEV_BUOY;
      if (req_rx_byte == icsm_pkg::CHAR_I) begin
         letter_dev = icsm_pkg::DEV_MODEM;
      end else if (req_rx_byte == icsm_pkg::CHAR_S) begin
         letter_dev = icsm_pkg::DEV_SENSOR;
      end else if (req_rx_byte == icsm_pkg::CHAR_B) begin
         letter_dev = icsm_pkg::DEV_BUOY;
      end else begin
         letter_ok = 1'b0;
      end
   end

   // classify the byte against the parse state
   always_comb begin
      mode_in         = mode_ff;
      pending_in      = pending_ff;
      raw_count_in    = raw_count_ff;
      push_entry.op   = icsm_pkg::OP_NONE;
      push_entry.dev  = letter_dev;
      push_entry.data = req_rx_byte;
      case (mode_ff)
         icsm_pkg::MODE_RAW: begin
            push_entry.op = icsm_pkg::OP_FWD;
            if (raw_count_ff <= RAW_COUNT_BITS'(1)) begin
               raw_count_in = '0;
               mode_in      = icsm_pkg::MODE_NORMAL;
            end else begin
               raw_count_in = raw_count_ff - RAW_COUNT_BITS'(1);
            end
         end
         icsm_pkg::MODE_ARG: begin
            mode_in    = icsm_pkg::MODE_NORMAL;
            pending_in = 3'd0;
            case (pending_ff)
               icsm_pkg::CMD_ANTENNA: begin
                  if (req_rx_byte == icsm_pkg::CHAR_G) begin
                     push_entry.op = icsm_pkg::OP_ANT_GPS;
                  end else if (req_rx_byte == icsm_pkg::CHAR_I) begin
                     push_entry.op = icsm_pkg::OP_ANT_SAT;
                  end
               end
               icsm_pkg::CMD_RAW_BYTE: begin
                  push_entry.op = icsm_pkg::OP_FWD;
               end
               icsm_pkg::CMD_CONNECT: begin
                  if (letter_ok) begin
                     push_entry.op = icsm_pkg::OP_CONNECT;
                  end
               end
               icsm_pkg::CMD_POWEROFF: begin
                  if (letter_ok) begin
                     push_entry.op = icsm_pkg::OP_POWEROFF;
                  end
               end
               icsm_pkg::CMD_RAW_LEN: begin
                  mode_in = icsm_pkg::MODE_RAW;
                  if (req_rx_byte == 8'd0) begin
                     raw_count_in = RAW_COUNT_BITS'(1);
                  end else begin
                     raw_count_in = RAW_COUNT_BITS'(req_rx_byte);
                  end
               end
               default: begin
                  push_entry.op = icsm_pkg::OP_NONE;
               end
            endcase
         end
         default: begin
            // normal, and the unused mode code
            mode_in = icsm_pkg::MODE_NORMAL;
            if (req_rx_byte < icsm_pkg::CMD_LIMIT) begin
               mode_in    = icsm_pkg::MODE_ARG;
               pending_in = req_rx_byte[2:0];
            end else begin
               push_entry.op = icsm_pkg::OP_FWD;
            end
         end
      endcase
      push_entry.mode = mode_in;
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= icsm_pkg::MODE_NORMAL;
         pending_ff   <= 3'd0;
         raw_count_ff <= '0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         pending_ff   <= pending_in;
         raw_count_ff <= raw_count_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/icsm_queue.sv -----
// two-entry queue between the front parser and the back executor
// uses icsm_pkg for the entry type
`default_nettype none

module icsm_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire icsm_pkg::icsm_entry_type push_entry,
   output logic                          push_stall,
   output logic                          pop_valid,
   output icsm_pkg::icsm_entry_type      pop_entry,
   input  wire logic                     pop_stall
);

   icsm_pkg::icsm_entry_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_stall = (count_ff == 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = mem[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- sv/icsm_back.sv -----
// back end: applies operations to antenna, power and link state
// and holds the result transaction; uses icsm_pkg
`default_nettype none

module icsm_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     pop_valid,
   input  wire icsm_pkg::icsm_entry_type pop_entry,
   output logic                          pop_stall,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_fwd_valid,
   output logic [1:0]                    rsp_fwd_dest,
   output logic [7:0]                    rsp_fwd_data,
   output logic                          rsp_antenna_sel,
   output logic                          rsp_pwr_buoy,
   output logic                          rsp_pwr_sensor,
   output logic                          rsp_pwr_modem,
   output logic [1:0]                    rsp_linked_dev,
   output logic                          rsp_link_open,
   output logic [1:0]                    rsp_parse_mode
);

   logic       valid_ff, valid_in;
   logic       fwd_ff, fwd_in;
   logic [1:0] dest_ff, dest_in;
   logic [7:0] data_ff, data_in;
   logic [1:0] mode_ff;
   logic       antenna_ff, antenna_in;
   logic [2:0] power_ff, power_in;
   logic [1:0] linked_ff, linked_in;
   logic       open_ff, open_in;
   logic       take;

   // load a new result when the output register is empty or being drained
   assign pop_stall = valid_ff && rsp_stall;
   assign take      = pop_valid && !pop_stall;

   // execute one operation
   always_comb begin
      antenna_in = antenna_ff;
      power_in   = power_ff;
      linked_in  = linked_ff;
      open_in    = open_ff;
      fwd_in     = 1'b0;
      dest_in    = icsm_pkg::DEV_BUOY;
      data_in    = 8'd0;
      case (pop_entry.op)
         icsm_pkg::OP_FWD: begin
            if (open_ff) begin
               fwd_in  = 1'b1;
               dest_in = linked_ff;
               data_in = pop_entry.data;
            end
         end
         icsm_pkg::OP_ANT_GPS: begin
            antenna_in = 1'b0;
         end
         icsm_pkg::OP_ANT_SAT: begin
            antenna_in = 1'b1;
         end
         icsm_pkg::OP_CONNECT: begin
            linked_in                = pop_entry.dev;
            power_in[pop_entry.dev]  = 1'b1;
            open_in                  = 1'b1;
         end
         icsm_pkg::OP_POWEROFF: begin
            if (power_ff[pop_entry.dev]) begin
               power_in[pop_entry.dev] = 1'b0;
               if (pop_entry.dev == linked_ff) begin
                  linked_in = icsm_pkg::DEV_BUOY;
                  open_in   = 1'b0;
               end
            end
         end
         default: begin
            fwd_in = 1'b0;
         end
      endcase
      valid_in = take || (valid_ff && rsp_stall);
   end

   // device state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         antenna_ff <= 1'b0;
         power_ff   <= icsm_pkg::POWER_RESET;
         linked_ff  <= icsm_pkg::DEV_SENSOR;
         open_ff    <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            antenna_ff <= antenna_in;
            power_ff   <= power_in;
            linked_ff  <= linked_in;
            open_ff    <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         fwd_ff  <= fwd_in;
         dest_ff <= dest_in;
         data_ff <= data_in;
         mode_ff <= pop_entry.mode;
      end
   end

   // state only moves when a new result loads, so it matches the held result
   assign rsp_valid       = valid_ff;
   assign rsp_fwd_valid   = fwd_ff;
   assign rsp_fwd_dest    = dest_ff;
   assign rsp_fwd_data    = data_ff;
   assign rsp_antenna_sel = antenna_ff;
   assign rsp_pwr_buoy    = power_ff[0];
   assign rsp_pwr_sensor  = power_ff[1];
   assign rsp_pwr_modem   = power_ff[2];
   assign rsp_linked_dev  = linked_ff;
   assign rsp_link_open   = open_ff;
   assign rsp_parse_mode  = mode_ff;

endmodule

`default_nettype wire
